[src/bis_pkg.sv]
package bis_pkg;

    localparam int DEF_MAX_ITEMS   = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_COMPARE,
        ST_SHIFT_CHK,
        ST_SHIFT_WR,
        ST_OUT_RD,
        ST_OUT_SHOW
    } state_t;

    typedef struct packed {
        logic load;
        logic mark_drop;
        logic search_init;
        logic read_mid;
        logic step;
        logic shift_init;
        logic read_shift;
        logic write_shift;
        logic insert;
        logic read_out;
        logic out_next;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic found;
        logic shift_done;
        logic last_pending;
        logic out_final;
    } status_t;

endpackage

[src/binary_insertion_sorter.sv]
// Each item is placed by S probes and then M moves, where S (at most about log2 of the fill) is the
// number of binary search probes and M the entries moved up, all through the single memory port.
// After the last item of a set, each sorted value is read and then shown once the previous one is taken.
// Reset (rst_n, asynchronous, active low) empties the set, clears the overflow flag and selects
// ascending order; the value store itself is not cleared and needs no clearing pass.
module binary_insertion_sorter #(
    parameter int MAX_ITEMS   = bis_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_WIDTH = bis_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] item_value,
    input  logic                          last_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] sorted_value,
    output logic                          last_out,
    output logic                          overflowed
);
    import bis_pkg::*;

    cmd_t    cmd;
    status_t status;

    bis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bis_datapath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .item_value   (item_value),
        .last_item    (last_item),
        .cmd          (cmd),
        .status       (status),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflowed   (overflowed)
    );

endmodule

[src/bis_ctrl.sv]
module bis_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  bis_pkg::status_t status,
    output bis_pkg::cmd_t    cmd
);
    import bis_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.full)
                begin
                    cmd.mark_drop = 1'b1;
                    state_next    = status.last_pending ? ST_OUT_RD : ST_IDLE;
                end
                else
                begin
                    cmd.search_init = 1'b1;
                    state_next      = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (status.found)
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = ST_SHIFT_CHK;
                end
                else
                begin
                    cmd.read_mid = 1'b1;
                    state_next   = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                cmd.step   = 1'b1;
                state_next = ST_SEARCH;
            end
            ST_SHIFT_CHK:
            begin
                if (status.shift_done)
                begin
                    cmd.insert = 1'b1;
                    state_next = status.last_pending ? ST_OUT_RD : ST_IDLE;
                end
                else
                begin
                    cmd.read_shift = 1'b1;
                    state_next     = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.write_shift = 1'b1;
                state_next      = ST_SHIFT_CHK;
            end
            ST_OUT_RD:
            begin
                cmd.read_out = 1'b1;
                state_next   = ST_OUT_SHOW;
            end
            ST_OUT_SHOW:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (status.out_final)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.out_next = 1'b1;
                        state_next   = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/bis_datapath.sv]
module bis_datapath #(
    parameter int MAX_ITEMS   = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic                          cfg_data,
    input  logic signed [VALUE_WIDTH-1:0] item_value,
    input  logic                          last_item,
    input  bis_pkg::cmd_t                 cmd,
    output bis_pkg::status_t              status,
    output logic signed [VALUE_WIDTH-1:0] sorted_value,
    output logic                          last_out,
    output logic                          overflowed
);
    import bis_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);

    logic signed [VALUE_WIDTH-1:0] mem [MAX_ITEMS];

    logic                          descending_reg;
    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic                          last_reg;
    logic signed [VALUE_WIDTH-1:0] rd_data_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          dropped_reg;
    logic                          dropped_next;
    logic [CW-1:0]                 lo_reg;
    logic [CW-1:0]                 lo_next;
    logic [CW-1:0]                 hi_reg;
    logic [CW-1:0]                 hi_next;
    logic [CW-1:0]                 j_reg;
    logic [CW-1:0]                 j_next;
    logic [CW-1:0]                 k_reg;
    logic [CW-1:0]                 k_next;

    logic [CW:0]                   mid_sum;
    logic [CW-1:0]                 mid;
    logic [CW-1:0]                 j_minus;
    logic                          goes_before;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic signed [VALUE_WIDTH-1:0] wr_data;

    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid         = mid_sum[CW:1];
    assign j_minus     = j_reg - 1'b1;
    assign goes_before = descending_reg ? (rd_data_reg < value_reg)
                                        : (value_reg < rd_data_reg);

    always_comb
    begin
        rd_en   = cmd.read_mid | cmd.read_shift | cmd.read_out;
        rd_addr = k_reg[AW-1:0];
        if (cmd.read_mid)
        begin
            rd_addr = mid[AW-1:0];
        end
        else if (cmd.read_shift)
        begin
            rd_addr = j_minus[AW-1:0];
        end
        wr_en   = cmd.write_shift | cmd.insert;
        wr_addr = cmd.insert ? hi_reg[AW-1:0] : j_reg[AW-1:0];
        wr_data = cmd.insert ? value_reg : rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= item_value;
            last_reg  <= last_item;
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        if (cmd.mark_drop)
        begin
            dropped_next = 1'b1;
        end
        if (cmd.search_init)
        begin
            lo_next = '0;
            hi_next = count_reg;
        end
        if (cmd.step)
        begin
            if (goes_before)
            begin
                hi_next = mid;
            end
            else
            begin
                lo_next = mid + 1'b1;
            end
        end
        if (cmd.shift_init)
        begin
            j_next = count_reg;
        end
        if (cmd.write_shift)
        begin
            j_next = j_minus;
        end
        if (cmd.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.out_next)
        begin
            k_next = k_reg + 1'b1;
        end
        if (cmd.clear)
        begin
            count_next   = '0;
            dropped_next = 1'b0;
            k_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg <= 1'b0;
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                descending_reg <= cfg_data;
            end
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
        end
    end

    assign status.full         = (count_reg == CW'(MAX_ITEMS));
    assign status.found        = (lo_reg == hi_reg);
    assign status.shift_done   = (j_reg == hi_reg);
    assign status.last_pending = last_reg;
    assign status.out_final    = ((k_reg + 1'b1) == count_reg);

    assign sorted_value = rd_data_reg;
    assign last_out     = status.out_final;
    assign overflowed   = dropped_reg;

endmodule
